// ===== sv/smsr_pkg.sv =====
// stepper speed ramp controller: shared types, codes and widths
// used by smsr_profile and step_motor_speed_ramp_controller_unit
`timescale 1ns / 1ps
`default_nettype none

package smsr_pkg;

   localparam int RATE_BITS = 16;
   localparam int CFG_BITS  = 16;
   localparam int MODE_BITS = 7;
   localparam int SUM_BITS  = ((RATE_BITS > CFG_BITS) ? RATE_BITS : CFG_BITS) + 1;

   localparam logic [RATE_BITS-1:0] RATE_MAX = {RATE_BITS{1'b1}};

   // event kinds
   localparam logic [2:0] KIND_CTRL_TICK   = 3'd0;
   localparam logic [2:0] KIND_MS_TICK     = 3'd1;
   localparam logic [2:0] KIND_START       = 3'd2;
   localparam logic [2:0] KIND_STOP        = 3'd3;
   localparam logic [2:0] KIND_EMERGENCY   = 3'd4;
   localparam logic [2:0] KIND_REDUCE_SENS = 3'd5;
   localparam logic [2:0] KIND_STOP_SENS   = 3'd6;

   // motor state codes
   localparam logic [3:0] MS_IDLE     = 4'd0;
   localparam logic [3:0] MS_ACCEL    = 4'd1;
   localparam logic [3:0] MS_STEADY   = 4'd2;
   localparam logic [3:0] MS_OVERRUN  = 4'd3;
   localparam logic [3:0] MS_DECEL    = 4'd4;
   localparam logic [3:0] MS_BRAKE    = 4'd5;
   localparam logic [3:0] MS_BRAKING  = 4'd6;
   localparam logic [3:0] MS_HALTING  = 4'd7;
   localparam logic [3:0] MS_STOP     = 4'd8;

   // register indexes
   localparam logic [2:0] REG_START_RATE   = 3'd0;
   localparam logic [2:0] REG_ACCEL_STEP   = 3'd1;
   localparam logic [2:0] REG_FIXED_RATE   = 3'd2;
   localparam logic [2:0] REG_DECEL_STEP   = 3'd3;
   localparam logic [2:0] REG_STOP_RATE    = 3'd4;
   localparam logic [2:0] REG_OVERRUN_TIME = 3'd5;
   localparam logic [2:0] REG_BRAKE_TIME   = 3'd6;
   localparam logic [2:0] REG_MODE_BITS    = 3'd7;

   // mode bit positions
   localparam int MODE_DIR            = 0;
   localparam int MODE_KEEP_HOLD      = 1;
   localparam int MODE_CHECK_FINISH   = 2;
   localparam int MODE_CHECK_START    = 3;
   localparam int MODE_START_PRESENT  = 4;
   localparam int MODE_REDUCE_PRESENT = 5;
   localparam int MODE_STOP_PRESENT   = 6;

   typedef struct packed {
      logic [CFG_BITS-1:0]  start_rate;
      logic [CFG_BITS-1:0]  accel_step;
      logic [CFG_BITS-1:0]  fixed_rate;
      logic [CFG_BITS-1:0]  decel_step;
      logic [CFG_BITS-1:0]  stop_rate;
      logic [CFG_BITS-1:0]  overrun_time;
      logic [CFG_BITS-1:0]  brake_time;
      logic [MODE_BITS-1:0] mode_bits;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       start_level;
      logic       reduce_level;
      logic       stop_level;
   } event_type;

   typedef struct packed {
      logic [3:0]  motor_state;
      logic [15:0] pulse_rate;
      logic        rate_write;
      logic        brake_cmd;
      logic        release_cmd;
      logic        direction;
      logic        fault;
      logic        start_rejected;
      logic        stable_event;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/smsr_profile.sv =====
// speed profile sequencer: state, rate, delay timer and latches
// updated once per transferred event; depends on smsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module smsr_profile (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire smsr_pkg::cfg_type   cfg,
   input  wire smsr_pkg::event_type evt,
   output smsr_pkg::result_type     result
);

   typedef enum logic [3:0] {
      ST_IDLE     = smsr_pkg::MS_IDLE,
      ST_ACCEL    = smsr_pkg::MS_ACCEL,
      ST_CONST    = smsr_pkg::MS_STEADY,
      ST_OVERRUN  = smsr_pkg::MS_OVERRUN,
      ST_DECEL    = smsr_pkg::MS_DECEL,
      ST_BRAKE    = smsr_pkg::MS_BRAKE,
      ST_BRAKING  = smsr_pkg::MS_BRAKING,
      ST_STOPPING = smsr_pkg::MS_HALTING,
      ST_STOP     = smsr_pkg::MS_STOP
   } state_type;

   state_type                          state_ff, state_in;
   logic [smsr_pkg::RATE_BITS-1:0]     rate_ff, rate_in;
   logic [smsr_pkg::CFG_BITS-1:0]      delay_ff, delay_in;
   logic                               fault_ff, fault_in;
   logic                               dir_ff, dir_in;

   logic [smsr_pkg::SUM_BITS-1:0]      rate_ext, accel_sum, step_ext, stop_ext;
   logic [smsr_pkg::RATE_BITS-1:0]     fixed_r, start_r, accel_rate, decel_rate;
   logic [smsr_pkg::CFG_BITS-1:0]      delay_dec;
   logic                               decel_ok, stop_ok, start_bad;
   state_type                          stop_state;
   logic [smsr_pkg::CFG_BITS-1:0]      stop_delay;
   logic [smsr_pkg::MODE_BITS-1:0]     mode;

   assign mode       = cfg.mode_bits;
   assign rate_ext   = smsr_pkg::SUM_BITS'(rate_ff);
   assign step_ext   = smsr_pkg::SUM_BITS'(cfg.decel_step);
   assign stop_ext   = smsr_pkg::SUM_BITS'(cfg.stop_rate);
   assign accel_sum  = rate_ext + smsr_pkg::SUM_BITS'(cfg.accel_step);
   assign fixed_r    = smsr_pkg::RATE_BITS'(cfg.fixed_rate);
   assign start_r    = smsr_pkg::RATE_BITS'(cfg.start_rate);
   assign accel_rate = (accel_sum > smsr_pkg::SUM_BITS'(smsr_pkg::RATE_MAX)) ?
                       smsr_pkg::RATE_MAX : smsr_pkg::RATE_BITS'(accel_sum);
   assign decel_ok   = (cfg.decel_step != '0) && (rate_ext > step_ext) &&
                       (rate_ext > stop_ext);
   assign decel_rate = smsr_pkg::RATE_BITS'(rate_ext - step_ext);
   assign delay_dec  = delay_ff - smsr_pkg::CFG_BITS'(1);

   // stop request: overrun first when a run-on time is set
   assign stop_ok    = state_ff inside {ST_ACCEL, ST_CONST, ST_OVERRUN};
   assign stop_state = (cfg.overrun_time != '0) ? ST_OVERRUN : ST_DECEL;
   assign stop_delay = (cfg.overrun_time != '0) ? cfg.overrun_time : delay_ff;

   assign start_bad  = mode[smsr_pkg::MODE_CHECK_START] &&
                       ((mode[smsr_pkg::MODE_START_PRESENT] && !evt.start_level) ||
                        (mode[smsr_pkg::MODE_REDUCE_PRESENT] && evt.reduce_level) ||
                        (mode[smsr_pkg::MODE_STOP_PRESENT] && evt.stop_level));

   always_comb begin
      state_in = state_ff;
      rate_in  = rate_ff;
      delay_in = delay_ff;
      fault_in = fault_ff;
      dir_in   = dir_ff;
      result.rate_write     = 1'b0;
      result.brake_cmd      = 1'b0;
      result.release_cmd    = 1'b0;
      result.start_rejected = 1'b0;
      result.stable_event   = 1'b0;
      case (evt.kind)
         smsr_pkg::KIND_CTRL_TICK: begin
            if (state_ff == ST_ACCEL) begin
               if (rate_ff >= fixed_r) begin
                  rate_in  = fixed_r;
                  state_in = ST_CONST;
                  result.stable_event = 1'b1;
               end else begin
                  rate_in = accel_rate;
               end
            end else if (state_ff == ST_DECEL) begin
               if (decel_ok) begin
                  rate_in = decel_rate;
               end else begin
                  rate_in  = '0;
                  state_in = ST_BRAKE;
               end
            end
            result.rate_write = (rate_in != rate_ff) && (rate_in != '0);
            if (state_in == ST_BRAKE) begin
               result.brake_cmd = 1'b1;
               if (cfg.brake_time != '0) begin
                  delay_in = cfg.brake_time;
                  state_in = ST_BRAKING;
               end else begin
                  state_in = ST_STOPPING;
               end
            end
            if (state_in == ST_STOPPING) begin
               result.release_cmd = !mode[smsr_pkg::MODE_KEEP_HOLD];
               state_in = ST_STOP;
               if (mode[smsr_pkg::MODE_CHECK_FINISH] && mode[smsr_pkg::MODE_STOP_PRESENT] &&
                   !evt.stop_level) begin
                  fault_in = 1'b1;
               end
            end
         end
         smsr_pkg::KIND_MS_TICK: begin
            if (delay_ff != '0) begin
               delay_in = delay_dec;
               if (delay_dec == '0) begin
                  if (state_ff == ST_OVERRUN) begin
                     state_in = ST_DECEL;
                  end else if (state_ff == ST_BRAKING) begin
                     state_in = ST_STOPPING;
                  end
               end
            end
         end
         smsr_pkg::KIND_START: begin
            if (state_ff == ST_IDLE || state_ff == ST_STOP) begin
               if (start_bad) begin
                  result.start_rejected = 1'b1;
               end else begin
                  dir_in   = mode[smsr_pkg::MODE_DIR];
                  delay_in = '0;
                  if (cfg.accel_step != '0) begin
                     rate_in  = start_r;
                     state_in = ST_ACCEL;
                  end else begin
                     rate_in  = fixed_r;
                     state_in = ST_CONST;
                  end
                  result.rate_write = (rate_in != '0);
                  fault_in = 1'b0;
               end
            end
         end
         smsr_pkg::KIND_STOP: begin
            if (stop_ok) begin
               state_in = stop_state;
               delay_in = stop_delay;
            end
         end
         smsr_pkg::KIND_EMERGENCY: begin
            state_in = ST_BRAKE;
         end
         smsr_pkg::KIND_REDUCE_SENS: begin
            if (mode[smsr_pkg::MODE_REDUCE_PRESENT] && stop_ok && evt.reduce_level) begin
               state_in = stop_state;
               delay_in = stop_delay;
            end
         end
         smsr_pkg::KIND_STOP_SENS: begin
            if (mode[smsr_pkg::MODE_STOP_PRESENT] && evt.stop_level &&
                (state_ff inside {ST_ACCEL, ST_CONST, ST_OVERRUN, ST_DECEL})) begin
               state_in = ST_BRAKE;
            end
         end
         default: begin
         end
      endcase
      result.motor_state = state_in;
      result.pulse_rate  = 16'(rate_in);
      result.direction   = dir_in;
      result.fault       = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rate_ff  <= '0;
         delay_ff <= '0;
         fault_ff <= 1'b0;
         dir_ff   <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
         rate_ff  <= rate_in;
         delay_ff <= delay_in;
         fault_ff <= fault_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/step_motor_speed_ramp_controller_unit.sv =====
// stepper speed ramp controller, top level: register file, result register
// the result is registered and valid in the cycle after the request transfer
// throughput: one event per clock while the result side keeps up
// the result register frees itself in the cycle its transfer completes
// reset clears registers, profile state, rate, timer and latches; no result pending
// depends on smsr_pkg and smsr_profile
`timescale 1ns / 1ps
`default_nettype none

module step_motor_speed_ramp_controller_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic        req_start_sensor_level,
   input  wire logic        req_reduce_sensor_level,
   input  wire logic        req_stop_sensor_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_motor_state,
   output logic [15:0]      rsp_pulse_rate,
   output logic             rsp_rate_write,
   output logic             rsp_brake_cmd,
   output logic             rsp_release_cmd,
   output logic             rsp_direction,
   output logic             rsp_fault,
   output logic             rsp_start_rejected,
   output logic             rsp_stable_event,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   smsr_pkg::cfg_type    cfg_ff;
   smsr_pkg::event_type  evt;
   smsr_pkg::result_type result;
   smsr_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign evt.kind         = req_kind;
   assign evt.start_level  = req_start_sensor_level;
   assign evt.reduce_level = req_reduce_sensor_level;
   assign evt.stop_level   = req_stop_sensor_level;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            smsr_pkg::REG_START_RATE:   cfg_ff.start_rate   <= csr_wdata;
            smsr_pkg::REG_ACCEL_STEP:   cfg_ff.accel_step   <= csr_wdata;
            smsr_pkg::REG_FIXED_RATE:   cfg_ff.fixed_rate   <= csr_wdata;
            smsr_pkg::REG_DECEL_STEP:   cfg_ff.decel_step   <= csr_wdata;
            smsr_pkg::REG_STOP_RATE:    cfg_ff.stop_rate    <= csr_wdata;
            smsr_pkg::REG_OVERRUN_TIME: cfg_ff.overrun_time <= csr_wdata;
            smsr_pkg::REG_BRAKE_TIME:   cfg_ff.brake_time   <= csr_wdata;
            smsr_pkg::REG_MODE_BITS:
               cfg_ff.mode_bits <= csr_wdata[smsr_pkg::MODE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   smsr_profile u_profile (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_take),
      .cfg     (cfg_ff),
      .evt     (evt),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_state    = rsp_ff.motor_state;
   assign rsp_pulse_rate     = rsp_ff.pulse_rate;
   assign rsp_rate_write     = rsp_ff.rate_write;
   assign rsp_brake_cmd      = rsp_ff.brake_cmd;
   assign rsp_release_cmd    = rsp_ff.release_cmd;
   assign rsp_direction      = rsp_ff.direction;
   assign rsp_fault          = rsp_ff.fault;
   assign rsp_start_rejected = rsp_ff.start_rejected;
   assign rsp_stable_event   = rsp_ff.stable_event;

   // checks
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("request transfer without a result");

   a_brake_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brake_cmd) |->
         (rsp_motor_state == smsr_pkg::MS_BRAKING || rsp_motor_state == smsr_pkg::MS_STOP))
      else $error("brake applied outside braking or stop");

   a_release_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_release_cmd) |-> (rsp_motor_state == smsr_pkg::MS_STOP))
      else $error("coils released outside stop");

   a_stable_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stable_event) |-> (rsp_motor_state == smsr_pkg::MS_STEADY))
      else $error("stable event without constant speed");

endmodule

`default_nettype wire
